[hw/rtl/ppf_pkg.sv]
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the pixel packet framer.
// ----------------------------------------------------------------------------
package ppf_pkg;

	localparam int PAD_W       = 6;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int SIZE_W      = 11;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

	localparam logic [1:0] KIND_ADDR = 2'd0;
	localparam logic [1:0] KIND_PIX  = 2'd1;
	localparam logic [1:0] KIND_CKS  = 2'd2;
	localparam logic [1:0] KIND_TERM = 2'd3;

	localparam logic [7:0] TERM_BYTE = 8'd128;

	// One classified pixel: everything the emitter needs to send its bytes.
	typedef struct packed {
		logic             hdr;
		logic [23:0]      addr;
		logic [7:0]       pix;
		logic [PAD_W-1:0] pad;
		logic             cks;
		logic [7:0]       cks_val;
		logic             term;
	} cmd_t;

endpackage

[hw/rtl/ppf_classifier.sv]
// ----------------------------------------------------------------------------
// ppf_classifier
// Holds the size registers and frame position, and turns each pixel into a
// command for the emitter.
// ----------------------------------------------------------------------------
module ppf_classifier import ppf_pkg::*; #(
	parameter int PIXELS_PER_PACKET = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 pix_valid,
	input  logic [23:0]          pix_data,
	input  logic                 queue_full,
	output logic                 pix_ready,
	output logic                 push,
	output cmd_t                 cmd
);

	localparam int SLOT_W = $clog2(PIXELS_PER_PACKET + 1);
	localparam logic [SLOT_W-1:0] PPP_S = SLOT_W'(PIXELS_PER_PACKET);

	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [9:0]        col_q;
	logic [9:0]        row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [7:0]        cks_q;

	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic              col_end;
	logic              frame_end;
	logic [SLOT_W-1:0] slot_nxt;
	logic [19:0]       sum_b;
	logic [23:0]       addr;
	logic [7:0]        pix;
	logic [7:0]        base;
	logic              hdr;

	assign pix_ready = !queue_full;
	assign push      = pix_valid && !queue_full;

	always_comb begin
		w = (width_q == '0) ? SIZE_W'(1) :
			(width_q > SIZE_W'(1024)) ? SIZE_W'(1024) : width_q;
		h = (height_q == '0) ? SIZE_W'(1) :
			(height_q > SIZE_W'(1024)) ? SIZE_W'(1024) : height_q;
		col_end   = ({1'b0, col_q} + SIZE_W'(1)) >= w;
		frame_end = col_end && (({1'b0, row_q} + SIZE_W'(1)) >= h);
		hdr       = (slot_q == '0);
		slot_nxt  = slot_q + SLOT_W'(1);
		sum_b     = {1'b0, col_q, 9'd0} + {10'd0, row_q};
		if (w == SIZE_W'(640)) begin
			addr = {col_q, row_q, 4'd0};
		end else begin
			addr = {sum_b[17:0], 6'd0};
		end
		pix  = {pix_data[7:5], pix_data[15:13], pix_data[23:22]};
		base = hdr ? (addr[23:16] ^ addr[15:8] ^ addr[7:0]) : cks_q;
		cmd.hdr     = hdr;
		cmd.addr    = addr;
		cmd.pix     = pix;
		cmd.pad     = frame_end ? PAD_W'(PPP_S - slot_nxt) : '0;
		cmd.cks     = frame_end || (slot_nxt == PPP_S);
		cmd.cks_val = base ^ pix;
		cmd.term    = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(640);
			height_q <= SIZE_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			cks_q    <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
			end
			if (push) begin
				col_q <= col_end ? '0 : col_q + 10'd1;
				if (frame_end) begin
					row_q <= '0;
				end else if (col_end) begin
					row_q <= row_q + 10'd1;
				end
				if (cmd.cks) begin
					slot_q <= '0;
					cks_q  <= '0;
				end else begin
					slot_q <= slot_nxt;
					cks_q  <= cmd.cks_val;
				end
			end
		end
	end

`ifndef SYNTH
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < PPP_S)
		else $error("packet slot out of range");
`endif

endmodule

[hw/rtl/ppf_queue.sv]
// ----------------------------------------------------------------------------
// ppf_queue
// Short command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module ppf_queue import ppf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/ppf_emitter.sv]
// ----------------------------------------------------------------------------
// ppf_emitter
// Walks each command through the address, pixel, pad, checksum and terminator
// bytes it carries, one per cycle unless stalled, into a registered output.
// ----------------------------------------------------------------------------
module ppf_emitter import ppf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	typedef enum logic [2:0] {
		PH_A2,
		PH_A1,
		PH_A0,
		PH_PIX,
		PH_PAD,
		PH_CKS,
		PH_TERM
	} phase_t;

	phase_t     phase_q;
	logic       busy_q;
	cmd_t       cur_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_kind_q;
	logic       out_last_q;

	cmd_t       src;
	cmd_t       src_nxt;
	phase_t     ph;
	phase_t     ph_nxt;
	logic       done;
	logic       adv;
	logic       go;
	logic [7:0] byte_c;
	logic [1:0] kind_c;

	always_comb begin
		adv     = !out_valid_q || m_tready;
		go      = adv && (busy_q || head_valid);
		pop     = adv && !busy_q && head_valid;
		src     = busy_q ? cur_q : head;
		ph      = busy_q ? phase_q : (head.hdr ? PH_A2 : PH_PIX);
		src_nxt = src;
		ph_nxt  = ph;
		done    = 1'b0;
		byte_c  = 8'd0;
		kind_c  = KIND_PIX;
		case (ph)
			PH_A2: begin
				byte_c = src.addr[23:16];
				kind_c = KIND_ADDR;
				ph_nxt = PH_A1;
			end
			PH_A1: begin
				byte_c = src.addr[15:8];
				kind_c = KIND_ADDR;
				ph_nxt = PH_A0;
			end
			PH_A0: begin
				byte_c = src.addr[7:0];
				kind_c = KIND_ADDR;
				ph_nxt = PH_PIX;
			end
			PH_PIX: begin
				byte_c = src.pix;
				kind_c = KIND_PIX;
				if (src.pad != '0) begin
					ph_nxt = PH_PAD;
				end else if (src.cks) begin
					ph_nxt = PH_CKS;
				end else if (src.term) begin
					ph_nxt = PH_TERM;
				end else begin
					done = 1'b1;
				end
			end
			PH_PAD: begin
				byte_c      = 8'd0;
				kind_c      = KIND_PIX;
				src_nxt.pad = src.pad - PAD_W'(1);
				ph_nxt      = (src.pad == PAD_W'(1)) ? PH_CKS : PH_PAD;
			end
			PH_CKS: begin
				byte_c = src.cks_val;
				kind_c = KIND_CKS;
				if (src.term) begin
					ph_nxt = PH_TERM;
				end else begin
					done = 1'b1;
				end
			end
			PH_TERM: begin
				byte_c = TERM_BYTE;
				kind_c = KIND_TERM;
				done   = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_A2;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= byte_c;
				out_kind_q  <= kind_c;
				out_last_q  <= done;
				busy_q      <= !done;
				phase_q     <= ph_nxt;
				cur_q       <= src_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_TERM) |-> m_tlast)
		else $error("terminator byte not marked last");
	a_addr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_ADDR) |-> !m_tlast)
		else $error("address byte marked last");
`endif

endmodule

[hw/rtl/pixel_packet_framer_core.sv]
// ----------------------------------------------------------------------------
// pixel_packet_framer_core
// Frames RGB pixels into address, pixel and checksum byte packets.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle while its four-entry command queue has
// room, and sends one output byte per cycle while m_tready does not stall it.
// A pixel gives one to PIXELS_PER_PACKET+5 bytes, so the emitter's byte rate
// sets the sustained rate: with twelve pixels per packet, sixteen bytes per
// twelve pixels, plus the pad and terminator bytes at a frame's end. Size
// registers take effect for the next pixel and should be written while the
// block is idle.
// ----------------------------------------------------------------------------
module pixel_packet_framer_core import ppf_pkg::*; #(
	parameter int PIXELS_PER_PACKET = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // out_byte [7:0]
	output logic [1:0]           m_tuser,   // byte_kind [1:0]
	output logic                 m_tlast
);

	logic push;
	logic pop;
	logic full;
	logic head_valid;
	cmd_t push_cmd;
	cmd_t head;

	assign cfg_ready = 1'b1;

	ppf_classifier #(
		.PIXELS_PER_PACKET(PIXELS_PER_PACKET)
	) u_classifier (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (s_tvalid),
		.pix_data  (s_tdata),
		.queue_full(full),
		.pix_ready (s_tready),
		.push      (push),
		.cmd       (push_cmd)
	);

	ppf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	ppf_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
